>>> sv/mos_pkg.sv
// Shared constants and types for the ADC median filter.
// Depends on nothing; every other file of the block uses it.
package mos_pkg;

  localparam int MAX_SAMPLES = 32;
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 12;
  localparam int CFG_W    = 6;

  // Millivolt scaling: code * 3300 / 4095, rounded to nearest.
  localparam int FULL_SCALE_MV   = 3300;
  localparam int FULL_SCALE_CODE = 4095;
  localparam int ROUND_BIAS      = 2047;
  localparam int PROD_W          = 24;
  localparam int QUOT_W          = 13;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [MV_W-1:0]     mv_t;
  typedef logic [CNT_W-1:0]    cnt_t;
  typedef logic [IDX_W-1:0]    idx_t;
  typedef logic [CFG_W-1:0]    cfg_t;

  typedef struct packed {
    sample_t median_code;
    mv_t     median_millivolts;
  } result_t;

endpackage

>>> sv/mos_ifs.sv
// Valid/ready channel interfaces for samples, results and configuration.
// Depends on mos_pkg for the payload types.
interface mos_in_if;
  logic             valid;
  logic             ready;
  mos_pkg::sample_t adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface mos_out_if;
  logic             valid;
  logic             ready;
  mos_pkg::sample_t median_code;
  mos_pkg::mv_t     median_millivolts;
  modport source (output valid, output median_code, output median_millivolts, input ready);
  modport sink   (input valid, input median_code, input median_millivolts, output ready);
endinterface

interface mos_cfg_if;
  logic          valid;
  logic          ready;
  mos_pkg::cfg_t sample_count;
  modport source (output valid, output sample_count, input ready);
  modport sink   (input valid, input sample_count, output ready);
endinterface

>>> sv/median_of_adc_samples.sv
// Running median of 12-bit ADC samples, built as a chain of insertion cells.
// After the accept of the last sample of a measurement, a result word passes
// through median select, code fetch and scale, divide and the output register.
// Throughput: one sample word per cycle while the output side keeps taking words.
// Reset (rst_n low, synchronous) empties the measurement and sets sample_count to 1.
module median_of_adc_samples (
  input  logic      clk,
  input  logic      rst_n,
  mos_in_if.sink    in_chan,
  mos_out_if.source out_chan,
  mos_cfg_if.sink   cfg_chan
);
  import mos_pkg::*;

  // Count of samples held in the current measurement and the configured
  // measurement length. Entries of the chain at or above the fill count are
  // treated as empty, so the chain itself needs no clearing.
  cnt_t taken_r, taken_nxt;
  cnt_t count_r, count_nxt;

  // Median select stage: set when a measurement completes.
  logic sel_v_r;
  idx_t sel_idx_r;

  logic            advance;
  logic            accept;
  logic            done;
  logic            res_valid;
  result_t         res;
  logic [CNT_W:0]  filled;

  logic    cell_gt  [MAX_SAMPLES];
  sample_t cell_val [MAX_SAMPLES];

  // The whole result path moves together; it freezes only while a finished
  // word sits in the output register and the sink does not take it.
  assign advance       = !res_valid || out_chan.ready;
  assign in_chan.ready = advance;
  assign accept        = in_chan.valid && advance;
  assign cfg_chan.ready = 1'b1;

  // The measurement completes once the fill count, including this sample,
  // reaches the configured count (also when the count was lowered midway).
  assign filled = (CNT_W+1)'(taken_r) + (CNT_W+1)'(1);
  assign done   = filled >= (CNT_W+1)'(count_r);

  always_comb begin
    taken_nxt = taken_r;
    if (accept) begin
      taken_nxt = done ? '0 : CNT_W'(filled);
    end
  end

  // Writes are clamped into 1..MAX_SAMPLES.
  always_comb begin
    count_nxt = count_r;
    if (cfg_chan.valid) begin
      if (cfg_chan.sample_count == '0) begin
        count_nxt = CNT_W'(1);
      end else if (int'(cfg_chan.sample_count) > MAX_SAMPLES) begin
        count_nxt = CNT_W'(MAX_SAMPLES);
      end else begin
        count_nxt = CNT_W'(cfg_chan.sample_count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taken_r <= '0;
      count_r <= CNT_W'(1);
      sel_v_r <= 1'b0;
    end else begin
      taken_r <= taken_nxt;
      count_r <= count_nxt;
      if (advance) begin
        sel_v_r <= accept && done;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      sel_idx_r <= IDX_W'(count_r >> 1);
    end
  end

  // Insertion chain. Every cell compares its entry with the new sample; the
  // cells that hold larger entries (and the empty ones) take their lower
  // neighbor's entry, and the lowest of them takes the sample itself, so a
  // sample lands after any equal entries.
  for (genvar i = 0; i < MAX_SAMPLES; i++) begin : g_cell
    logic    prev_gt;
    sample_t prev_val;
    if (i == 0) begin : g_first
      assign prev_gt  = 1'b0;
      assign prev_val = '0;
    end else begin : g_rest
      assign prev_gt  = cell_gt[i-1];
      assign prev_val = cell_val[i-1];
    end

    mos_cell u_cell (
      .clk      (clk),
      .shift_en (accept),
      .held     (taken_r > CNT_W'(i)),
      .sample   (in_chan.adc_sample),
      .prev_gt  (prev_gt),
      .prev_val (prev_val),
      .gt       (cell_gt[i]),
      .val      (cell_val[i])
    );
  end

  // The cell contents read here are those right after the completing
  // insertion; a new sample accepted in this cycle changes them only at the
  // same edge that captures the median code.
  mos_scale u_scale (
    .clk        (clk),
    .rst_n      (rst_n),
    .advance    (advance),
    .code_valid (sel_v_r),
    .code       (cell_val[sel_idx_r]),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign out_chan.valid             = res_valid;
  assign out_chan.median_code       = res.median_code;
  assign out_chan.median_millivolts = res.median_millivolts;

endmodule

>>> sv/mos_cell.sv
// One cell of the insertion sorter chain: holds one sorted sample.
// Depends on mos_pkg.
module mos_cell (
  input  logic             clk,
  input  logic             shift_en,
  input  logic             held,
  input  mos_pkg::sample_t sample,
  input  logic             prev_gt,
  input  mos_pkg::sample_t prev_val,
  output logic             gt,
  output mos_pkg::sample_t val
);
  import mos_pkg::*;

  sample_t val_r;
  sample_t val_nxt;

  // An empty cell counts as larger than any sample.
  assign gt  = !held || (val_r > sample);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (gt) begin
      val_nxt = prev_gt ? prev_val : sample;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      val_r <= val_nxt;
    end
  end

endmodule

>>> sv/mos_scale.sv
// Millivolt conversion pipeline with the output register.
// Depends on mos_pkg; three stages, all advanced by one enable.
module mos_scale (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  logic              code_valid,
  input  mos_pkg::sample_t  code,
  output logic              res_valid,
  output mos_pkg::result_t  res
);
  import mos_pkg::*;

  logic                v1_r, v2_r, v3_r;
  sample_t             c1_r, c2_r;
  logic [PROD_W-1:0]   x1_r, x2_r;
  logic [QUOT_W-1:0]   q2_r;
  result_t             res_r;

  logic [PROD_W-1:0]   x_nxt;
  logic [PROD_W:0]     qsum;
  logic [QUOT_W-1:0]   q_nxt;
  logic [PROD_W:0]     qmul;
  logic [PROD_W:0]     rem;
  logic [QUOT_W-1:0]   q_fix;

  // Scale and add half the divisor for rounding.
  assign x_nxt = PROD_W'(code) * PROD_W'(FULL_SCALE_MV) + PROD_W'(ROUND_BIAS);

  // Divide by 2^12-1: x/4096 * (1 + 1/4096) undershoots by at most one.
  assign qsum  = (PROD_W+1)'(x1_r) + (PROD_W+1)'(x1_r >> 12);
  assign q_nxt = QUOT_W'(qsum >> 12);

  // One correction step from the remainder.
  assign qmul  = ((PROD_W+1)'(q2_r) << 12) - (PROD_W+1)'(q2_r);
  assign rem   = (PROD_W+1)'(x2_r) - qmul;
  assign q_fix = (rem >= (PROD_W+1)'(FULL_SCALE_CODE)) ? q2_r + QUOT_W'(1) : q2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= code_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c1_r                    <= code;
      x1_r                    <= x_nxt;
      c2_r                    <= c1_r;
      x2_r                    <= x1_r;
      q2_r                    <= q_nxt;
      res_r.median_code       <= c2_r;
      res_r.median_millivolts <= MV_W'(q_fix);
    end
  end

  assign res_valid = v3_r;
  assign res       = res_r;

endmodule

>>> tb/sv/tb_median_of_adc_samples.sv
// Self-checking testbench for the running median filter of ADC samples.
// Depends on mos_pkg and on the channel interfaces in mos_ifs.sv, both from the RTL.
module tb_median_of_adc_samples;
  timeunit 1ns;
  timeprecision 1ps;

  import mos_pkg::*;

  // Clock period, reset length and the quiet time that lets the insertion chain
  // and the four-stage output pipe settle before a count write.
  localparam int HALF_PERIOD   = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int LONG_HOLD     = 300;
  localparam int RANDOM_WORDS  = 1850;
  localparam int GAP_PERCENT   = 6;
  localparam int REPORT_LIMIT  = 10;

  // Kinds of row in the directed stimulus.
  typedef enum logic [1:0] {
    ROW_CFG,      // write sample_count with the row's value
    ROW_SAMPLE,   // send one sample word
    ROW_DESCEND   // send the row's value of samples in strictly falling order
  } row_kind_t;

  // Shapes of random sample content within one phase.
  typedef enum logic [2:0] {
    PAT_UNIFORM,
    PAT_EXTREME,
    PAT_CLUSTER,
    PAT_RISING,
    PAT_FALLING
  } pattern_t;

  typedef struct {
    row_kind_t   kind;
    int unsigned value;
    bit          typed;
    sample_t     code;
    mv_t         mv;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mos_in_if  in_bus ();
  mos_out_if out_bus ();
  mos_cfg_if cfg_bus ();

  median_of_adc_samples dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_bus),
    .out_chan (out_bus),
    .cfg_chan (cfg_bus)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // The directed part. Expected results are typed in only where they can be seen
  // at once; every other row goes through the predictor.
  stim_row_t stim_rows [25] = '{
    // After reset the count is 1, so every sample is its own median.
    '{ROW_SAMPLE,  0,    1'b1, 12'd0,    12'd0},
    '{ROW_SAMPLE,  4095, 1'b1, 12'd4095, 12'd3300},
    '{ROW_SAMPLE,  2048, 1'b0, 12'd0,    12'd0},
    // A count of zero acts as a count of one.
    '{ROW_CFG,     0,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  1,    1'b1, 12'd1,    12'd1},
    // Odd count, extremes arriving out of order.
    '{ROW_CFG,     3,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  4095, 1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  0,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  2048, 1'b0, 12'd0,    12'd0},
    // Even count picks the upper middle sample.
    '{ROW_CFG,     2,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  7,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  5,    1'b0, 12'd0,    12'd0},
    // Equal samples.
    '{ROW_CFG,     3,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  9,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  9,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  9,    1'b0, 12'd0,    12'd0},
    // Count lowered while three samples are held: the next sample ends it.
    '{ROW_CFG,     5,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  100,  1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  300,  1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  200,  1'b0, 12'd0,    12'd0},
    '{ROW_CFG,     2,    1'b0, 12'd0,    12'd0},
    '{ROW_SAMPLE,  50,   1'b0, 12'd0,    12'd0},
    // Counts above the store depth clamp to it; a falling run fills every entry
    // and makes each new sample shift the whole store.
    '{ROW_CFG,     63,   1'b0, 12'd0,    12'd0},
    '{ROW_DESCEND, 32,   1'b0, 12'd0,    12'd0},
    '{ROW_CFG,     33,   1'b0, 12'd0,    12'd0}
  };

  // Predictor state: the sorted samples of the measurement in progress, how many
  // are held, and the effective samples per median.
  sample_t sorted_codes [MAX_SAMPLES];
  int      codes_held   = 0;
  int      median_span  = 1;

  // Medians still owed by the block, oldest first.
  result_t median_q [$];

  int  fail_count     = 0;
  int  words_sent     = 0;
  int  medians_seen   = 0;
  int  count_writes   = 0;
  bit  tx_gaps        = 1'b1;
  bit  rx_gaps        = 1'b1;
  int  stall_requests = 0;
  int  stalls_served  = 0;
  int  hold_left      = 0;

  function automatic int clamp_span(cfg_t v);
    if (v == '0) return 1;
    if (int'(v) > MAX_SAMPLES) return MAX_SAMPLES;
    return int'(v);
  endfunction

  function automatic mv_t code_millivolts(sample_t code);
    return mv_t'((int'(code) * FULL_SCALE_MV + ROUND_BIAS) / FULL_SCALE_CODE);
  endfunction

  // Insert a sample after any equal ones and report the median once the
  // measurement is complete.
  task automatic insert_sample(input sample_t s, output bit done, output result_t med);
    int slot;
    slot = codes_held;
    if (slot >= MAX_SAMPLES) begin
      codes_held = 0;
      slot = 0;
    end
    while (slot > 0 && sorted_codes[slot-1] > s) begin
      sorted_codes[slot] = sorted_codes[slot-1];
      slot--;
    end
    sorted_codes[slot] = s;
    codes_held++;
    done = 1'b0;
    med  = '0;
    if (codes_held >= median_span) begin
      med.median_code       = sorted_codes[median_span / 2];
      med.median_millivolts = code_millivolts(med.median_code);
      codes_held = 0;
      done = 1'b1;
    end
  endtask

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("[%0t] %s", $realtime, msg);
  endfunction

  // Offer one sample word, with random idle cycles ahead of it when enabled, and
  // predict its effect on the accepting edge.
  task automatic put_word(input sample_t s, input bit typed = 1'b0,
                          input result_t typed_med = '0);
    bit      done;
    result_t med;
    while (tx_gaps && $urandom_range(99) < GAP_PERCENT) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.adc_sample <= s;
    do @(posedge clk); while (!in_bus.ready);
    words_sent++;
    insert_sample(s, done, med);
    if (done) median_q.push_back(typed ? typed_med : med);
  endtask

  // Stop offering words, wait for every owed median, then let the pipe settle.
  task automatic wait_idle();
    in_bus.valid <= 1'b0;
    while (median_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input cfg_t v);
    wait_idle();
    cfg_bus.valid        <= 1'b1;
    cfg_bus.sample_count <= v;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    median_span = clamp_span(v);
    count_writes++;
  endtask

  function automatic sample_t pick_sample(pattern_t pat, int k, sample_t base);
    int v;
    case (pat)
      PAT_EXTREME: begin
        case ($urandom_range(3))
          0: v = 0;
          1: v = 1;
          2: v = 4094;
          default: v = 4095;
        endcase
      end
      PAT_CLUSTER: v = int'(base) + $urandom_range(3);
      PAT_RISING:  v = int'(base) + k * $urandom_range(1, 40);
      PAT_FALLING: v = int'(base) - k * $urandom_range(1, 40);
      default:     v = $urandom_range(4095);
    endcase
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return sample_t'(v);
  endfunction

  // Result side: compare every accepted median word with the oldest prediction,
  // and drive ready with random stalls or a requested long hold.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      medians_seen++;
      if (median_q.size() == 0) begin
        note_failure($sformatf("unexpected median word: code %0d, mV %0d",
                               out_bus.median_code, out_bus.median_millivolts));
      end else begin
        want = median_q.pop_front();
        if (out_bus.median_code !== want.median_code)
          note_failure($sformatf("median_code: expected %0d, got %0d",
                                 want.median_code, out_bus.median_code));
        if (out_bus.median_millivolts !== want.median_millivolts)
          note_failure($sformatf("median_millivolts: expected %0d, got %0d",
                                 want.median_millivolts, out_bus.median_millivolts));
      end
    end
    if (stalls_served != stall_requests) begin
      stalls_served = stall_requests;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= !(rx_gaps && $urandom_range(99) < GAP_PERCENT);
    end
  end

  // Stimulus and the end of the run.
  initial begin
    int       phase;
    int       first_words;
    int       len;
    int       drain;
    cfg_t     next_count;
    pattern_t pat;
    sample_t  base;
    result_t  typed_med;
    cfg_t     opening_counts [7];

    opening_counts       = '{6'd63, 6'd32, 6'd0, 6'd1, 6'd33, 6'd2, 6'd31};
    rst_n                = 1'b0;
    in_bus.valid         = 1'b0;
    in_bus.adc_sample    = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.sample_count = '0;
    out_bus.ready        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows.
    foreach (stim_rows[i]) begin
      case (stim_rows[i].kind)
        ROW_CFG: write_count(cfg_t'(stim_rows[i].value));
        ROW_SAMPLE: begin
          typed_med.median_code       = stim_rows[i].code;
          typed_med.median_millivolts = stim_rows[i].mv;
          put_word(sample_t'(stim_rows[i].value), stim_rows[i].typed, typed_med);
        end
        default: begin
          for (int k = 0; k < int'(stim_rows[i].value); k++)
            put_word(sample_t'(4095 - k * 127));
        end
      endcase
    end

    // Random phases. Each one writes a new count while a partial measurement may
    // still be held, then sends a few whole measurements plus a random tail, so
    // counts are raised and lowered mid-measurement over and over.
    first_words = words_sent;
    phase = 0;
    while (words_sent - first_words < RANDOM_WORDS) begin
      // A stretch of phases with no idling on either side.
      tx_gaps = !(phase >= 10 && phase < 15);
      rx_gaps = tx_gaps;

      if (phase == 3 || phase == 25) begin
        // Back-pressure: a median per sample while the result side holds off for
        // a long stretch, so the block fills and stalls its input. Afterwards the
        // sender waits for every owed median before moving on.
        write_count(cfg_t'(1));
        tx_gaps = 1'b0;
        stall_requests++;
        for (int k = 0; k < 80; k++) put_word(sample_t'($urandom_range(4095)));
        wait_idle();
        tx_gaps = 1'b1;
      end

      if (phase < 7) begin
        next_count = opening_counts[phase];
      end else begin
        case ($urandom_range(9))
          0, 1, 2:    next_count = cfg_t'($urandom_range(63));
          3, 4:       next_count = cfg_t'($urandom_range(9, 32));
          default:    next_count = cfg_t'($urandom_range(1, 8));
        endcase
      end
      write_count(next_count);

      len  = median_span * $urandom_range(1, 4) + $urandom_range(median_span - 1);
      pat  = pattern_t'($urandom_range(4));
      base = sample_t'($urandom_range(4095));
      for (int k = 0; k < len; k++) put_word(pick_sample(pat, k, base));
      phase++;
    end

    // Wait out the owed medians, then watch for stray words.
    in_bus.valid <= 1'b0;
    drain = 0;
    while (median_q.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (median_q.size() != 0)
      note_failure($sformatf("%0d medians never arrived", median_q.size()));

    $display("Sent %0d sample words over %0d count writes in %0d random phases,",
             words_sent, count_writes, phase);
    $display("checked %0d median words; %0d failures.", medians_seen, fail_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Hard limit on the run, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> filelist.f
sv/mos_pkg.sv
sv/mos_ifs.sv
sv/mos_cell.sv
sv/mos_scale.sv
sv/median_of_adc_samples.sv
tb/sv/tb_median_of_adc_samples.sv
